### rtl/irt_pkg.sv
// Shared constants, types and command/status bundles for the radix text converter.
package irt_pkg;

   localparam int MAX_RADIX   = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int ALPHA_SLOTS = 16;
   localparam int CHAR_W      = 8;
   localparam int RADIX_W     = 5;
   localparam int DIGIT_W     = $clog2(MAX_RADIX);
   localparam int ADDR_W      = $clog2(VALUE_WIDTH);
   localparam int COUNT_W     = $clog2(VALUE_WIDTH + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
   localparam logic [RADIX_W-1:0] MIN_RADIX  = RADIX_W'(2);

   localparam logic [RADIX_W-1:0]    DIGIT_COUNT_RESET   = RADIX_W'(10);
   localparam logic [CSR_DATA_W-1:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] ALPHABET_HIGH_RESET = 64'h0000_0000_0000_3930;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIGIT_COUNT   = 2'd0,
      CSR_ALPHABET_LOW  = 2'd1,
      CSR_ALPHABET_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_SIGN,
      ST_FETCH,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic load_sign;
      logic fetch;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic alphabet_ok;
      logic div_last;
      logic quot_zero;
      logic negative;
      logic last_digit;
      logic digits_full;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/irt_channels.sv
// Valid/ready channel interfaces for input numbers, output characters and register writes.
interface irt_req_if
   import irt_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface irt_rsp_if
   import irt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              is_last;

   modport source (output valid, output character, output is_last, input ready);
   modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface irt_csr_if
   import irt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/irt_ctrl.sv
// Sequencing state machine: divide, store, then emit characters from the digit store.
module irt_ctrl
   import irt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.alphabet_ok) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_STORE;
         end
         ST_STORE: begin
            if (!status.quot_zero) state_in = ST_DIVIDE;
            else if (status.negative) state_in = ST_SIGN;
            else state_in = ST_FETCH;
         end
         ST_SIGN: begin
            if (status.out_free) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = status.last_digit ? ST_IDLE : ST_FETCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
         end
         ST_SIGN: begin
            cmd.load_sign = status.out_free;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### rtl/irt_dp.sv
// Datapath: config registers, alphabet check, serial divider, digit store and output register.
module irt_dp
   import irt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   output logic                          rsp_valid,
   output logic [CHAR_W-1:0]             rsp_character,
   output logic                          rsp_is_last,
   input  logic                          rsp_ready
);

   logic [RADIX_W-1:0]    digit_count_ff;
   logic [CSR_DATA_W-1:0] alpha_low_ff;
   logic [CSR_DATA_W-1:0] alpha_high_ff;
   logic [2*CSR_DATA_W-1:0] alpha_all;
   logic [CHAR_W-1:0]     chars [ALPHA_SLOTS];
   logic                  alphabet_bad;

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   negative_ff;
   logic [DIGIT_W:0]       trial;
   logic [DIGIT_W:0]       diff;
   logic                   ge;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [COUNT_W-1:0]     count_dec;

   logic [DIGIT_W-1:0]     digit_store_ff [VALUE_WIDTH];
   logic [DIGIT_W-1:0]     rd_digit_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
         alpha_low_ff   <= ALPHABET_LOW_RESET;
         alpha_high_ff  <= ALPHABET_HIGH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIGIT_COUNT:   digit_count_ff <= csr_data[RADIX_W-1:0];
            CSR_ALPHABET_LOW:  alpha_low_ff   <= csr_data;
            CSR_ALPHABET_HIGH: alpha_high_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign alpha_all = {alpha_high_ff, alpha_low_ff};

   // alphabet check: radix range, reserved characters and duplicates among the used slots
   always_comb begin
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         chars[i] = alpha_all[CHAR_W*i +: CHAR_W];
      end
      alphabet_bad = (digit_count_ff < MIN_RADIX) || (digit_count_ff > RADIX_W'(MAX_RADIX));
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         if (i < int'(digit_count_ff)) begin
            if (chars[i] == '0 || chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS) begin
               alphabet_bad = 1'b1;
            end
            for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
               if (j < int'(digit_count_ff) && chars[i] == chars[j]) alphabet_bad = 1'b1;
            end
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   assign magnitude = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
   assign trial     = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign diff      = trial - digit_count_ff;
   assign ge        = (trial >= digit_count_ff);
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         quot_in    = magnitude;
         rem_in     = '0;
         bit_cnt_in = '0;
         count_in   = '0;
      end else if (cmd.div_step) begin
         quot_in    = {quot_ff[VALUE_WIDTH-2:0], ge};
         rem_in     = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end else if (cmd.store) begin
         rem_in     = '0;
         bit_cnt_in = '0;
         count_in   = count_ff + 1'b1;
      end else if (cmd.emit) begin
         count_in   = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.load) negative_ff <= req_value[VALUE_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
         count_ff   <= '0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         count_ff   <= count_in;
      end
   end

   // digit store, least significant digit at entry zero
   always_ff @(posedge clock) begin
      if (cmd.store) digit_store_ff[count_ff[ADDR_W-1:0]] <= rem_ff;
      if (cmd.fetch) rd_digit_ff <= digit_store_ff[count_dec[ADDR_W-1:0]];
   end

   // output register
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (cmd.load_sign) begin
         out_valid_in = 1'b1;
         out_char_in  = CHAR_MINUS;
         out_last_in  = 1'b0;
      end else if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_char_in  = chars[rd_digit_ff];
         out_last_in  = (count_ff == COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_is_last   = out_last_ff;

   assign status.alphabet_ok = !alphabet_bad;
   assign status.div_last    = (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1));
   assign status.quot_zero   = (quot_ff == '0);
   assign status.negative    = negative_ff;
   assign status.last_digit  = (count_ff == COUNT_W'(1));
   assign status.digits_full = (count_ff >= COUNT_W'(VALUE_WIDTH));
   assign status.out_free    = out_free;

endmodule

### rtl/signed_int_to_radix_text_core.sv
// Top level of the signed integer to radix text converter.
// Takes one signed 32-bit number per item on req_chan and returns its text on rsp_chan,
// one character per item, most significant digit first, with a leading '-' for
// negative values (the most negative value is converted exactly) and is_last set on
// the final character. The radix is digit_count and the digits are alphabet
// characters 0..15 packed in alphabet_low/alphabet_high (csr_chan indexes 0, 1, 2).
// An alphabet with fewer than 2 or more than 16 characters, or holding '+', '-', a
// zero byte or a repeat, makes the item produce no characters; such an item is
// accepted and dropped. Otherwise each digit costs 32 quotient steps in the
// one-bit-per-cycle restoring divider plus a store into the digit memory, and each
// character then needs a fetch because the digit memory read is registered before
// lookup; the receiver can stall any character, the sign included. One item is in
// work at a time; the output register lets the next item be accepted while the last
// character waits.
// Write registers only while no conversion is running.
module signed_int_to_radix_text_core
   import irt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   irt_req_if.sink      req_chan,
   irt_rsp_if.source    rsp_chan,
   irt_csr_if.sink      csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   irt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   irt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .req_value     (req_chan.value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_character (rsp_chan.character),
      .rsp_is_last   (rsp_chan.is_last),
      .rsp_ready     (rsp_chan.ready)
   );

`ifndef NO_ASSERTIONS
   // drop an item with a bad alphabet: the block is ready again next cycle
   a_bad_alphabet_drops: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready && !status.alphabet_ok) |=> req_chan.ready)
      else $error("item with bad alphabet did not return to idle");

   // never write past the end of the digit store
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !status.digits_full)
      else $error("digit store overflow");

   // emit a sign only for negative values
   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sign |-> status.negative)
      else $error("minus sign for a non-negative value");

   // loading a character never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.load_sign) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("output character overwritten");
`endif

endmodule
